>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: function codes,
// controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] FN_NORM = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_CMP  = 3'd2;
  localparam logic [2:0] FN_INC  = 3'd3;
  localparam logic [2:0] FN_DEC  = 3'd4;

  typedef enum logic [1:0] {
    MUL_SEL_P,
    MUL_SEL_Q,
    MUL_SEL_D
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_MUL_P,
    ST_MUL_Q,
    ST_MUL_D,
    ST_SUM,
    ST_STRIP,
    ST_GCD,
    ST_DIV_N_INIT,
    ST_DIV_N,
    ST_DIV_D_INIT,
    ST_DIV_D,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     norm_ld;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sum_ld;
    logic     strip;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_init;
    logic     div_den;
    logic     div_step;
    logic     save_num;
    logic     res_ld;
  } rau_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       both_zero;
    logic       both_even;
    logic       gcd_done;
  } rau_stat_t;

endpackage

>>> rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational arithmetic unit: walks one item through the
// passes its function needs: multiply, sum, strip, gcd and the two quotient passes.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  rau_stat_t stat_i,
  output rau_cmd_t  cmd_o
);

  localparam int CW = $clog2(WIDTH);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cnt_last;

  assign cnt_last = (cnt_q == CW'(WIDTH - 1));
  assign busy     = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_DISP;
      end
      ST_DISP: begin
        if (stat_i.func == FN_NORM) begin
          state_d = ST_STRIP;
        end else if (stat_i.func == FN_ADD || stat_i.func == FN_DEC ||
                     stat_i.func == FN_CMP) begin
          state_d = ST_MUL_P;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL_P: state_d = ST_MUL_Q;
      ST_MUL_Q: state_d = (stat_i.func == FN_CMP) ? ST_FIN : ST_MUL_D;
      ST_MUL_D: state_d = ST_SUM;
      ST_SUM:   state_d = ST_STRIP;
      ST_STRIP: begin
        if (stat_i.both_zero) begin
          state_d = ST_FIN;
        end else if (!stat_i.both_even) begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (stat_i.gcd_done) state_d = ST_DIV_N_INIT;
      end
      ST_DIV_N_INIT: state_d = ST_DIV_N;
      ST_DIV_N: begin
        if (cnt_last) state_d = ST_DIV_D_INIT;
      end
      ST_DIV_D_INIT: state_d = ST_DIV_D;
      ST_DIV_D: begin
        if (cnt_last) state_d = ST_FIN;
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // step counter of the quotient passes
  always_comb begin
    cnt_d = cnt_q;
    case (state_q)
      ST_DIV_N_INIT, ST_DIV_D_INIT: cnt_d = '0;
      ST_DIV_N, ST_DIV_D:           cnt_d = cnt_q + 1'b1;
      default:                      cnt_d = cnt_q;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_SEL_P;
    case (state_q)
      ST_IDLE: cmd_o.load = start;
      ST_DISP: cmd_o.norm_ld = (stat_i.func == FN_NORM);
      ST_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SEL_P;
      end
      ST_MUL_Q: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SEL_Q;
      end
      ST_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SEL_D;
      end
      ST_SUM: cmd_o.sum_ld = 1'b1;
      ST_STRIP: begin
        cmd_o.strip    = !stat_i.both_zero && stat_i.both_even;
        cmd_o.gcd_init = !stat_i.both_zero && !stat_i.both_even;
      end
      ST_GCD: cmd_o.gcd_step = !stat_i.gcd_done;
      ST_DIV_N_INIT: cmd_o.div_init = 1'b1;
      ST_DIV_N:      cmd_o.div_step = 1'b1;
      ST_DIV_D_INIT: begin
        cmd_o.save_num = 1'b1;
        cmd_o.div_init = 1'b1;
        cmd_o.div_den  = 1'b1;
      end
      ST_DIV_D: cmd_o.div_step = 1'b1;
      ST_FIN:   cmd_o.res_ld = 1'b1;
      default:  cmd_o.load = 1'b0;
    endcase
  end

endmodule

>>> rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath of the rational arithmetic unit: operand registers, one shared
// multiplier, binary gcd, restoring quotient unit and result registers.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rau_cmd_t                cmd_i,
  output rau_stat_t               stat_o,
  input  logic [2:0]              func_i,
  input  logic signed [WIDTH-1:0] a_num_i,
  input  logic signed [WIDTH-1:0] a_den_i,
  input  logic signed [WIDTH-1:0] b_num_i,
  input  logic signed [WIDTH-1:0] b_den_i,
  output logic                    done_o,
  output logic signed [WIDTH-1:0] res_num_o,
  output logic [WIDTH-2:0]        res_den_o,
  output logic                    less_o,
  output logic                    equal_o,
  output logic                    overflow_o,
  output logic                    div_zero_o
);

  localparam int MW = 2 * WIDTH;
  localparam int DW = 3 * WIDTH - 1;
  localparam logic [WIDTH-1:0] Lim = {1'b1, {(WIDTH-1){1'b0}}};

  logic [2:0]              func_q;
  logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [MW-1:0]    pp_q, pq_q, pd_q;
  logic [MW-1:0]           num_q, den_q;
  logic                    nneg_q, dneg_q;
  logic [MW-1:0]           x_q, y_q;
  logic [MW-1:0]           rem_q;
  logic [DW-1:0]           ds_q;
  logic [WIDTH-1:0]        quo_q, qn_q;
  logic                    big_q, nbig_q;

  logic signed [WIDTH-1:0] res_num_q, res_num_d;
  logic [WIDTH-2:0]        res_den_q, res_den_d;
  logic                    less_q, less_d, equal_q, equal_d;
  logic                    ovf_q, ovf_d, dz_q, dz_d, done_q;

  // operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      an_q   <= a_num_i;
      ad_q   <= a_den_i;
      bn_q   <= (func_i == FN_DEC) ? '1 : b_num_i;
      bd_q   <= (func_i == FN_DEC) ? WIDTH'(1) : b_den_i;
    end
  end

  // shared multiplier
  logic signed [WIDTH-1:0] mul_a, mul_b;
  logic signed [MW-1:0]    prod;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SEL_P: begin mul_a = an_q; mul_b = bd_q; end
      MUL_SEL_Q: begin mul_a = bn_q; mul_b = ad_q; end
      MUL_SEL_D: begin mul_a = ad_q; mul_b = bd_q; end
      default:   begin mul_a = an_q; mul_b = bd_q; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_SEL_P: pp_q <= prod;
        MUL_SEL_Q: pq_q <= prod;
        MUL_SEL_D: pd_q <= prod;
        default:   pp_q <= prod;
      endcase
    end
  end

  // sign and magnitude of the fraction to reduce
  logic [WIDTH:0]       an_ext, ad_ext, an_mag, ad_mag;
  logic signed [MW:0]   sum;
  logic [MW:0]          sum_mag;
  logic [MW-1:0]        pd_mag;

  assign an_ext  = {an_q[WIDTH-1], an_q};
  assign ad_ext  = {ad_q[WIDTH-1], ad_q};
  assign an_mag  = an_q[WIDTH-1] ? (~an_ext + 1'b1) : an_ext;
  assign ad_mag  = ad_q[WIDTH-1] ? (~ad_ext + 1'b1) : ad_ext;
  assign sum     = {pp_q[MW-1], pp_q} + {pq_q[MW-1], pq_q};
  assign sum_mag = sum[MW] ? (~sum + 1'b1) : sum;
  assign pd_mag  = pd_q[MW-1] ? (~pd_q + 1'b1) : pd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_ld) begin
      num_q  <= MW'(an_mag);
      den_q  <= MW'(ad_mag);
      nneg_q <= an_q[WIDTH-1];
      dneg_q <= ad_q[WIDTH-1];
    end else if (cmd_i.sum_ld) begin
      num_q  <= sum_mag[MW-1:0];
      den_q  <= pd_mag;
      nneg_q <= sum[MW];
      dneg_q <= pd_q[MW-1];
    end else if (cmd_i.strip) begin
      num_q  <= num_q >> 1;
      den_q  <= den_q >> 1;
    end
  end

  // binary gcd of the odd part
  logic [MW-1:0] h;
  logic          x_ge_y;

  assign h      = x_q | y_q;
  assign x_ge_y = (x_q >= y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      x_q <= num_q;
      y_q <= den_q;
    end else if (cmd_i.gcd_step) begin
      if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_ge_y) begin
        x_q <= (x_q - y_q) >> 1;
      end else begin
        y_q <= (y_q - x_q) >> 1;
      end
    end
  end

  // restoring quotient unit, one quotient bit per step
  logic [MW-1:0] dvd;
  logic [DW-1:0] rem_ext;
  logic          rem_ge;

  assign dvd     = cmd_i.div_den ? den_q : num_q;
  assign rem_ext = {{(WIDTH-1){1'b0}}, rem_q};
  assign rem_ge  = (rem_ext >= ds_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= dvd;
      ds_q  <= {h, {(WIDTH-1){1'b0}}};
      quo_q <= '0;
      big_q <= ({{WIDTH{1'b0}}, dvd} >= {h, {WIDTH{1'b0}}});
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - ds_q[MW-1:0];
      end
      quo_q <= {quo_q[WIDTH-2:0], rem_ge};
      ds_q  <= ds_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_num) begin
      qn_q   <= quo_q;
      nbig_q <= big_q;
    end
  end

  // result selection
  logic                  neg, red_ovf;
  logic [WIDTH:0]        inc_sum;

  assign neg     = (nneg_q != dneg_q) && (num_q != '0);
  assign red_ovf = nbig_q || big_q || quo_q[WIDTH-1] ||
                   (neg ? (qn_q > Lim) : (qn_q >= Lim));
  assign inc_sum = an_ext + ad_ext;

  always_comb begin
    res_num_d = '0;
    res_den_d = '0;
    less_d    = 1'b0;
    equal_d   = 1'b0;
    ovf_d     = 1'b0;
    dz_d      = 1'b0;
    case (func_q)
      FN_NORM, FN_ADD, FN_DEC: begin
        if (num_q == '0 && den_q == '0) begin
          dz_d = 1'b1;
        end else if (red_ovf) begin
          ovf_d = 1'b1;
        end else begin
          res_num_d = neg ? (~qn_q + 1'b1) : qn_q;
          res_den_d = quo_q[WIDTH-2:0];
        end
      end
      FN_CMP: begin
        less_d  = (pp_q < pq_q);
        equal_d = (an_q == bn_q) && (ad_q == bd_q);
      end
      FN_INC: begin
        if (ad_q[WIDTH-1] || (inc_sum[WIDTH] != inc_sum[WIDTH-1])) begin
          ovf_d = 1'b1;
        end else begin
          res_num_d = inc_sum[WIDTH-1:0];
          res_den_d = ad_q[WIDTH-2:0];
        end
      end
      default: begin
        ovf_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      res_num_q <= res_num_d;
      res_den_q <= res_den_d;
      less_q    <= less_d;
      equal_q   <= equal_d;
      ovf_q     <= ovf_d;
      dz_q      <= dz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_ld;
    end
  end

  assign stat_o.func      = func_q;
  assign stat_o.both_zero = (num_q == '0) && (den_q == '0);
  assign stat_o.both_even = !num_q[0] && !den_q[0];
  assign stat_o.gcd_done  = (x_q == '0) || (y_q == '0);

  assign done_o     = done_q;
  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign less_o     = less_q;
  assign equal_o    = equal_q;
  assign overflow_o = ovf_q;
  assign div_zero_o = dz_q;

endmodule

>>> rtl/rational_arith_unit.sv
// Increment and unused codes go from dispatch straight to the result; compare
// runs only the first two multiplies; normalize reduces operand a by common-two
// strip, binary gcd and quotient steps; add and decrement first multiply and sum,
// then reduce the same way; zero over zero skips gcd and quotient.
// One item at a time; the next start is taken in the cycle done_o is high.
// rst_ni clears the sequencer and done_o asynchronously; the receiver cannot stall.
// ----------------------------------------------------------------------------
// rational_arith_unit
// Rational-number ALU: normalize, add, compare, increment and decrement of
// fractions, with gcd reduction and range flags.
// ----------------------------------------------------------------------------
module rational_arith_unit import rau_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              func_i,
  input  logic signed [WIDTH-1:0] a_num_i,
  input  logic signed [WIDTH-1:0] a_den_i,
  input  logic signed [WIDTH-1:0] b_num_i,
  input  logic signed [WIDTH-1:0] b_den_i,
  output logic                    done_o,
  output logic signed [WIDTH-1:0] res_num_o,
  output logic [WIDTH-2:0]        res_den_o,
  output logic                    less_o,
  output logic                    equal_o,
  output logic                    overflow_o,
  output logic                    div_zero_o
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .func_i     (func_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .done_o     (done_o),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .less_o     (less_o),
    .equal_o    (equal_o),
    .overflow_o (overflow_o),
    .div_zero_o (div_zero_o)
  );

endmodule
